FILE: sv/lsss_pkg.sv
// ----------------------------------------------------------------------------
// lsss_pkg
// Shared types and constants for the light seek servo stepper.
// ----------------------------------------------------------------------------
package lsss_pkg;

    localparam int TICKS_PER_STEP = 5;
    localparam int CNT_W          = 4;

    localparam int ANGLE_W   = 8;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = SAMPLE_W + 1;
    localparam int AMB_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd2;

    localparam logic [ANGLE_W-1:0] NEUTRAL_RESET = 8'd90;
    localparam logic [ANGLE_W-1:0] MIN_RESET     = 8'd0;
    localparam logic [ANGLE_W-1:0] MAX_RESET     = 8'd180;

    // Step thresholds on the sample difference
    localparam logic [SAMPLE_W-1:0] DIFF_LARGE   = 10'd200;
    localparam logic [SAMPLE_W-1:0] DIFF_MEDIUM  = 10'd100;
    localparam logic [SAMPLE_W-1:0] DIFF_BALANCE = 10'd2;

    localparam logic [3:0] STEP_LARGE  = 4'd10;
    localparam logic [3:0] STEP_MEDIUM = 4'd5;
    localparam logic [3:0] STEP_SMALL  = 4'd1;

    // Ambient class bounds on the sample sum
    localparam logic [SUM_W-1:0] AMB_VBRIGHT_LT = 11'd500;
    localparam logic [SUM_W-1:0] AMB_BRIGHT_LT  = 11'd1500;
    localparam logic [SUM_W-1:0] AMB_DIM_LE     = 11'd2000;

    localparam logic [AMB_W-1:0] AMB_VERY_BRIGHT = 2'd0;
    localparam logic [AMB_W-1:0] AMB_BRIGHT      = 2'd1;
    localparam logic [AMB_W-1:0] AMB_DIM         = 2'd2;
    localparam logic [AMB_W-1:0] AMB_DARK        = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic [ANGLE_W-1:0] neutral_angle;
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
    } t_cfg;

    typedef struct packed {
        logic                search_active;
        logic [CNT_W-1:0]    tick_count;
        logic [SAMPLE_W-1:0] left_latched;
        logic [SAMPLE_W-1:0] right_latched;
        logic [ANGLE_W-1:0]  head_angle;
    } t_state;

    typedef struct packed {
        logic               servo_valid;
        logic [ANGLE_W-1:0] servo_angle;
        logic               found;
        logic [AMB_W-1:0]   ambient_class;
    } t_result;

endpackage

FILE: sv/lsss_regs.sv
// ----------------------------------------------------------------------------
// lsss_regs
// Configuration register file: neutral, minimum and maximum head angle.
// ----------------------------------------------------------------------------
module lsss_regs
    import lsss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_idx,
    input  logic [ANGLE_W-1:0]   i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_angle <= NEUTRAL_RESET;
            r_cfg.min_angle     <= MIN_RESET;
            r_cfg.max_angle     <= MAX_RESET;
        end else if (i_wr_en) begin
            // drop writes to unused indexes
            unique case (i_wr_idx)
                REG_NEUTRAL: r_cfg.neutral_angle <= i_wr_data;
                REG_MIN:     r_cfg.min_angle     <= i_wr_data;
                REG_MAX:     r_cfg.max_angle     <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/lsss_step.sv
// ----------------------------------------------------------------------------
// lsss_step
// Single-pass step logic: next search state and result for one request.
// ----------------------------------------------------------------------------
module lsss_step
    import lsss_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    input  logic                i_cmd,
    input  logic [SAMPLE_W-1:0] i_left,
    input  logic [SAMPLE_W-1:0] i_right,
    output t_state              o_state,
    output logic                o_res_valid,
    output t_result             o_res
);

    logic [CNT_W-1:0]    cnt_inc;
    logic [SUM_W-1:0]    sum;
    logic                toward_left;
    logic [SAMPLE_W-1:0] diff;
    logic [3:0]          step;
    logic                balanced;
    logic signed [ANGLE_W+1:0] angle;
    logic signed [ANGLE_W+1:0] head_s;
    logic signed [ANGLE_W+1:0] step_s;
    logic                in_range;
    logic [ANGLE_W-1:0]  angle_sat;
    logic [AMB_W-1:0]    amb;

    assign cnt_inc     = i_state.tick_count + CNT_W'(1);
    assign sum         = SUM_W'(i_state.left_latched) + SUM_W'(i_state.right_latched);
    assign toward_left = i_state.left_latched < i_state.right_latched;
    assign diff        = toward_left ? (i_state.right_latched - i_state.left_latched)
                                     : (i_state.left_latched - i_state.right_latched);
    assign balanced    = diff < DIFF_BALANCE;

    always_comb begin
        priority if (diff > DIFF_LARGE)  step = STEP_LARGE;
        else if (diff > DIFF_MEDIUM)     step = STEP_MEDIUM;
        else                             step = STEP_SMALL;
    end

    always_comb begin
        priority if (sum < AMB_VBRIGHT_LT) amb = AMB_VERY_BRIGHT;
        else if (sum < AMB_BRIGHT_LT)      amb = AMB_BRIGHT;
        else if (sum <= AMB_DIM_LE)        amb = AMB_DIM;
        else                               amb = AMB_DARK;
    end

    // full-range angle, no 8-bit wrap
    assign head_s = $signed({2'b00, i_state.head_angle});
    assign step_s = $signed({{(ANGLE_W-2){1'b0}}, step});
    assign angle  = toward_left ? (head_s - step_s) : (head_s + step_s);

    assign in_range = (angle <= $signed({2'b00, i_cfg.max_angle}))
                   && (angle >= $signed({2'b00, i_cfg.min_angle}));

    always_comb begin
        priority if (angle < 0)                      angle_sat = '0;
        else if (angle > $signed(10'sd255))          angle_sat = '1;
        else                                         angle_sat = angle[ANGLE_W-1:0];
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_cmd == CMD_START) begin
            o_state.search_active = 1'b1;
            o_state.tick_count    = '0;
            o_state.left_latched  = '0;
            o_state.right_latched = '0;
            o_state.head_angle    = i_cfg.neutral_angle;
            o_res_valid           = 1'b1;
            o_res.servo_valid     = 1'b1;
            o_res.servo_angle     = i_cfg.neutral_angle;
        end else if (i_state.search_active) begin
            if (cnt_inc != CNT_W'(TICKS_PER_STEP)) begin
                // latch samples, no result
                o_state.tick_count    = cnt_inc;
                o_state.left_latched  = i_left;
                o_state.right_latched = i_right;
            end else begin
                o_state.tick_count    = '0;
                o_state.head_angle    = angle_sat;
                o_state.search_active = !(balanced || !in_range);
                o_res_valid           = 1'b1;
                o_res.servo_valid     = in_range;
                o_res.servo_angle     = in_range ? angle_sat : '0;
                o_res.found           = balanced || !in_range;
                o_res.ambient_class   = amb;
            end
        end
    end

endmodule

FILE: sv/light_seek_servo_stepper.sv
// ----------------------------------------------------------------------------
// light_seek_servo_stepper
// Steers a head servo toward the brighter of two light sensors in steps.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Content
//  s_axis    in         tvalid / tready        tuser: cmd; tdata: left, right
//  m_axis    out        tvalid / tready        tuser: servo_valid, found;
//                                              tdata: servo_angle, ambient_class
//  cfg       in         valid / ready          idx 0 neutral, 1 min, 2 max
//
//  Flow: one request per cycle sustained while the result register is free
//  or drained. A request is held in the input register, then the step logic
//  updates the search state and, for a request that produces a result, loads
//  the result register, which drives tvalid.
//  Reset (synchronous, active low) clears the search, the tick counter, the
//  latched samples and loads the register defaults.
//  Stalls: when the result register is full and not taken, the input
//  register holds and tready drops once it is also full.
// ----------------------------------------------------------------------------
module light_seek_servo_stepper
    import lsss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [23:0]          i_s_axis_tdata,   // [9:0] left_sample, [19:10] right_sample
    input  logic                 i_s_axis_tuser,   // [0] cmd

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [7:0] servo_angle, [9:8] ambient_class
    output logic [1:0]           o_m_axis_tuser,   // [0] servo_valid, [1] found

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ANGLE_W-1:0]   i_cfg_data
);

    t_cfg    cfg;

    // input register
    logic                r_in_valid;
    logic                r_cmd;
    logic [SAMPLE_W-1:0] r_left;
    logic [SAMPLE_W-1:0] r_right;

    // search state
    t_state  r_state;
    t_state  n_state;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    n_out_valid;

    logic    advance;
    logic    in_take;

    assign o_cfg_ready = 1'b1;

    lsss_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    lsss_step u_step (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_cmd       (r_cmd),
        .i_left      (r_left),
        .i_right     (r_right),
        .o_state     (n_state),
        .o_res_valid (n_out_valid),
        .o_res       (n_out)
    );

    // Advance the held request when the result register is free or drained
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd   <= i_s_axis_tuser;
            r_left  <= i_s_axis_tdata[SAMPLE_W-1:0];
            r_right <= i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    // Search state commits when the request advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.search_active <= 1'b0;
            r_state.tick_count    <= '0;
            r_state.left_latched  <= '0;
            r_state.right_latched <= '0;
            r_state.head_angle    <= NEUTRAL_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a producing advance, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.ambient_class, r_out.servo_angle};
    assign o_m_axis_tuser  = {r_out.found, r_out.servo_valid};

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for light_seek_servo_stepper: a queue-fed stream driver
// with random gaps, a result monitor with random back-pressure, and an
// in-bench model of the search that predicts every servo result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsss_pkg::*;

    // Step thresholds and sizes of the search, kept apart from the package
    // so that a wrong constant in the design shows up as a mismatch.
    localparam int DIFF_COARSE = 200;
    localparam int DIFF_FINE   = 100;
    localparam int DIFF_EVEN   = 2;
    localparam int MOVE_COARSE = 10;
    localparam int MOVE_FINE   = 5;
    localparam int MOVE_TRIM   = 1;
    localparam int SUM_VBRIGHT = 500;
    localparam int SUM_BRIGHT  = 1500;
    localparam int SUM_DIM     = 2000;

    // Index past the register list: the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int N_SETUPS      = 12;
    localparam int REQS_PER_SETUP = 128;
    localparam int DRAIN_CYCLES  = 8;
    localparam int GAP_MAX       = 12;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } light_req_t;

    typedef struct packed {
        logic               servo_valid;
        logic [ANGLE_W-1:0] angle;
        logic               found;
        logic [AMB_W-1:0]   amb;
    } servo_move_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [23:0]          i_s_axis_tdata  = '0;
    logic                 i_s_axis_tuser  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr      = '0;
    logic [ANGLE_W-1:0]   i_cfg_data      = '0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [15:0]          o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;
    logic                 o_cfg_ready;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    light_seek_servo_stepper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Search model: own copy of the registers and the search state
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]  cfg_neutral = NEUTRAL_RESET;
    logic [ANGLE_W-1:0]  cfg_min     = MIN_RESET;
    logic [ANGLE_W-1:0]  cfg_max     = MAX_RESET;

    logic                armed     = 1'b0;
    int unsigned         tick_no   = 0;
    logic [SAMPLE_W-1:0] left_hold = '0;
    logic [SAMPLE_W-1:0] right_hold = '0;
    logic [ANGLE_W-1:0]  head      = NEUTRAL_RESET;

    servo_move_t moves_due[$];     // servo results still owed by the block

    int unsigned n_results   = 0;
    int unsigned n_found     = 0;
    int unsigned n_off_limit = 0;
    int unsigned n_restarts  = 0;
    int unsigned n_errors    = 0;

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [ANGLE_W-1:0] val);
        case (idx)
            REG_NEUTRAL: cfg_neutral = val;
            REG_MIN:     cfg_min     = val;
            REG_MAX:     cfg_max     = val;
            default: ;
        endcase
    endfunction

    // Advance the search by one accepted request; queue the servo result
    // it causes, if any.
    function automatic void step_search(input light_req_t req);
        int          l;
        int          r;
        int          total;
        int          diff;
        int          mag;
        int          target;
        logic        to_left;
        logic        ended;
        logic        in_lim;
        servo_move_t m;

        if (req.cmd == CMD_START) begin
            if (armed) n_restarts++;
            armed      = 1'b1;
            left_hold  = '0;
            right_hold = '0;
            tick_no    = 0;
            head       = cfg_neutral;
            m = '{1'b1, cfg_neutral, 1'b0, AMB_VERY_BRIGHT};
            moves_due.push_back(m);
            return;
        end

        // Drop ticks while no search is armed
        if (!armed) return;

        tick_no++;
        if (tick_no != TICKS_PER_STEP) begin
            left_hold  = req.left;
            right_hold = req.right;
            return;
        end
        tick_no = 0;

        // Step tick: its own samples are ignored, the held pair decides
        l     = int'(left_hold);
        r     = int'(right_hold);
        total = l + r;
        to_left = (l < r);
        diff  = to_left ? r - l : l - r;
        ended = 1'b0;
        if (diff > DIFF_COARSE) mag = MOVE_COARSE;
        else if (diff > DIFF_FINE) mag = MOVE_FINE;
        else begin
            mag = MOVE_TRIM;
            if (diff < DIFF_EVEN) ended = 1'b1;
        end

        // Full-width angle: no 8-bit wrap before the limit check
        target = int'(head) + (to_left ? -mag : mag);
        in_lim = (target >= int'(cfg_min)) && (target <= int'(cfg_max));
        if (!in_lim) begin
            ended = 1'b1;
            n_off_limit++;
        end
        if (ended) begin
            armed = 1'b0;
            n_found++;
        end

        if (target < 0) head = '0;
        else if (target > 255) head = '1;
        else head = target[ANGLE_W-1:0];

        m.servo_valid = in_lim;
        m.angle       = in_lim ? head : '0;
        m.found       = ended;
        if (total < SUM_VBRIGHT) m.amb = AMB_VERY_BRIGHT;
        else if (total < SUM_BRIGHT) m.amb = AMB_BRIGHT;
        else if (total <= SUM_DIM) m.amb = AMB_DIM;
        else m.amb = AMB_DARK;
        moves_due.push_back(m);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop the queue, hold each request until taken
    // ------------------------------------------------------------------
    light_req_t  pending_reqs[$];
    light_req_t  req_now   = '0;
    logic        req_live  = 1'b0;
    logic        req_taken = 1'b0;
    logic        req_burst = 1'b0;
    int unsigned req_gap   = 0;
    int unsigned n_queued  = 0;
    int unsigned n_taken   = 0;

    always @(negedge i_clk) begin
        if (req_taken) begin
            req_live  = 1'b0;
            req_taken = 1'b0;
        end
        if (!req_live && i_rst_n) begin
            if (req_gap != 0) begin
                req_gap--;
            end else if (pending_reqs.size() != 0) begin
                req_now  = pending_reqs.pop_front();
                req_live = 1'b1;
                // Switch now and then between back-to-back and gapped runs
                if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
                req_gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
        end
        // One assignment per signal: a request taken and replaced in the
        // same cycle keeps tvalid high without a glitch
        i_s_axis_tvalid <= req_live;
        i_s_axis_tdata  <= {4'b0000, req_now.right, req_now.left};
        i_s_axis_tuser  <= req_now.cmd;
    end

    // Take requests at the rising edge and feed them to the model
    always @(posedge i_clk) begin
        light_req_t got_req;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            got_req.cmd   = i_s_axis_tuser;
            got_req.left  = i_s_axis_tdata[SAMPLE_W-1:0];
            got_req.right = i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            step_search(got_req);
            req_taken = 1'b1;
            n_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall after each result, compare in order
    // ------------------------------------------------------------------
    int unsigned hold_left  = 0;
    logic        hold_burst = 1'b0;
    logic        move_taken = 1'b0;

    always @(negedge i_clk) begin
        if (move_taken) begin
            move_taken = 1'b0;
            if ($urandom_range(0, 15) == 0) hold_burst = !hold_burst;
            hold_left = hold_burst ? 0 : $urandom_range(0, GAP_MAX);
        end else if (hold_left != 0) begin
            hold_left--;
        end
        i_m_axis_tready <= i_rst_n && (hold_left == 0);
    end

    always @(posedge i_clk) begin
        servo_move_t got;
        servo_move_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.servo_valid = o_m_axis_tuser[0];
            got.found       = o_m_axis_tuser[1];
            got.angle       = o_m_axis_tdata[ANGLE_W-1:0];
            got.amb         = o_m_axis_tdata[ANGLE_W+AMB_W-1:ANGLE_W];
            move_taken = 1'b1;
            n_results++;
            if (moves_due.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result, expected none, %s",
                         $time, "got:");
                $display("  valid=%0b angle=%0d found=%0b class=%0d",
                         got.servo_valid, got.angle, got.found, got.amb);
            end else begin
                want = moves_due.pop_front();
                if (got !== want) begin
                    n_errors++;
                    $display("%0t ns: result %0d expected valid=%0b angle=%0d found=%0b class=%0d,",
                             $time, n_results, want.servo_valid, want.angle,
                             want.found, want.amb);
                    $display("  got valid=%0b angle=%0d found=%0b class=%0d",
                             got.servo_valid, got.angle, got.found, got.amb);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] any_sample();
        bit [31:0] w;
        w = $urandom();
        return w[SAMPLE_W-1:0];
    endfunction

    task automatic push_req(input logic cmd, input logic [SAMPLE_W-1:0] l,
                            input logic [SAMPLE_W-1:0] r);
        light_req_t q;
        q.cmd   = cmd;
        q.left  = l;
        q.right = r;
        pending_reqs.push_back(q);
        n_queued++;
    endtask

    // One search step: latching ticks with the decisive pair on the last,
    // then the step tick carrying throwaway samples
    task automatic push_step(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        repeat (TICKS_PER_STEP - 2) push_req(CMD_TICK, any_sample(), any_sample());
        push_req(CMD_TICK, l, r);
        push_req(CMD_TICK, any_sample(), any_sample());
    endtask

    // Draw a sample pair aimed at the step sizes, their boundaries, the
    // balanced case and the ambient class boundaries. Returns {right, left}.
    function automatic logic [2*SAMPLE_W-1:0] pick_pair();
        int        rims[6]  = '{99, 100, 101, 199, 200, 201};
        int        sums[8]  = '{0, 499, 500, 1499, 1500, 2000, 2001, 2046};
        int        diff;
        int        lo;
        int        l;
        int        r;
        int        total;
        bit [31:0] w;
        diff = 0;
        case ($urandom_range(0, 11))
            0:       diff = $urandom_range(0, 1);
            1, 2:    diff = $urandom_range(2, 100);
            3:       diff = rims[$urandom_range(0, 5)];
            4, 5:    diff = $urandom_range(101, 200);
            6, 7, 8: diff = $urandom_range(201, 1023);
            9: begin
                w = $urandom();
                return w[2*SAMPLE_W-1:0];
            end
            default: begin
                total = sums[$urandom_range(0, 7)];
                l = $urandom_range(total > 1023 ? total - 1023 : 0,
                                   total < 1023 ? total : 1023);
                r = total - l;
                return {r[SAMPLE_W-1:0], l[SAMPLE_W-1:0]};
            end
        endcase
        lo = $urandom_range(0, 1023 - diff);
        if ($urandom_range(0, 1) == 0) begin
            l = lo;
            r = lo + diff;
        end else begin
            l = lo + diff;
            r = lo;
        end
        return {r[SAMPLE_W-1:0], l[SAMPLE_W-1:0]};
    endfunction

    // A start followed by a run of steps; now and then a step is cut short
    // by a fresh start, and stray requests trail the run
    task automatic push_search();
        logic [2*SAMPLE_W-1:0] pr;
        push_req(CMD_START, any_sample(), any_sample());
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 29) == 0) begin
                repeat ($urandom_range(0, TICKS_PER_STEP - 1))
                    push_req(CMD_TICK, any_sample(), any_sample());
                push_req(CMD_START, any_sample(), any_sample());
            end
            pr = pick_pair();
            push_step(pr[SAMPLE_W-1:0], pr[2*SAMPLE_W-1:SAMPLE_W]);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                push_req(($urandom_range(0, 7) == 0) ? CMD_START : CMD_TICK,
                         any_sample(), any_sample());
    endtask

    // Wait until every request is taken and every result is in, then give
    // requests that cause no result time to clear the pipeline
    task automatic settle();
        while (n_taken != n_queued || moves_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned       mark;
        logic [ANGLE_W-1:0] nv;
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        bit [31:0]          w;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed run on the reset register values
        push_req(CMD_TICK, 10'd1023, 10'd0);     // tick with no search armed
        push_req(CMD_START, 10'd0, 10'd1023);
        push_step(10'd1023, 10'd0);              // coarse step right
        push_step(10'd150, 10'd300);             // fine step left, very bright
        push_step(10'd700, 10'd900);             // difference at the coarse bound: fine step, dim
        push_req(CMD_TICK, 10'd512, 10'd511);
        push_req(CMD_TICK, 10'd0, 10'd0);
        push_req(CMD_START, 10'd1023, 10'd1023); // restart mid-step
        push_step(10'd1000, 10'd1001);           // balanced in range, dark
        settle();

        // Random searches under a series of register settings: extremes, narrow
        // windows, an empty window, single-angle windows, then random windows
        for (int s = 0; s < N_SETUPS; s++) begin
            case (s)
                0: begin nv = 8'd0;   lo = 8'd0;   hi = 8'd255; end
                1: begin nv = 8'd255; lo = 8'd0;   hi = 8'd255; end
                2: begin nv = 8'd128; lo = 8'd100; hi = 8'd150; end
                3: begin nv = 8'd50;  lo = 8'd60;  hi = 8'd40;  end
                4: begin nv = 8'd90;  lo = 8'd0;   hi = 8'd180; end
                5: begin nv = 8'd200; lo = 8'd195; hi = 8'd205; end
                6: begin nv = 8'd255; lo = 8'd255; hi = 8'd255; end
                7: begin nv = 8'd0;   lo = 8'd0;   hi = 8'd0;   end
                default: begin
                    w  = $urandom();
                    nv = w[ANGLE_W-1:0];
                    w  = $urandom_range(0, nv);
                    lo = w[ANGLE_W-1:0];
                    w  = $urandom_range(nv, 255);
                    hi = w[ANGLE_W-1:0];
                    if (s == N_SETUPS - 1) begin
                        w  = $urandom();
                        lo = w[ANGLE_W-1:0];
                        hi = w[2*ANGLE_W-1:ANGLE_W];
                    end
                end
            endcase
            w = $urandom();
            write_reg(REG_SPARE, w[ANGLE_W-1:0]);   // must leave all registers alone
            write_reg(REG_NEUTRAL, nv);
            write_reg(REG_MIN, lo);
            write_reg(REG_MAX, hi);

            mark = n_queued;
            while (n_queued - mark < REQS_PER_SETUP) push_search();
            settle();
        end

        $display("Covered %0d requests over %0d register settings: %0d results,",
                 n_taken, N_SETUPS + 1, n_results);
        $display("  %0d searches ended, %0d off-limit steps, %0d restarts while armed, %0d errors.",
                 n_found, n_off_limit, n_restarts, n_errors);
        if (n_errors == 0) begin
            $display("light_seek_servo_stepper: match");
        end else begin
            $display("light_seek_servo_stepper: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout: %0d of %0d requests taken, %0d results still due.",
                 n_taken, n_queued, moves_due.size());
        $display("light_seek_servo_stepper: mismatch");
        $finish;
    end

endmodule
